>>> hw/rtl/pwmd_pkg.sv
// ----------------------------------------------------------------------------
// pwmd_pkg
// Shared constants and types of the PWM throttle pulse decoder.
// ----------------------------------------------------------------------------
package pwmd_pkg;

  localparam int unsigned COUNT_BITS = 16;
  localparam int unsigned SPEED_BITS = 16;
  localparam int unsigned CFG_IDX_BITS = 2;

  localparam int unsigned WIDTH_LOW  = 1000;
  localparam int unsigned WIDTH_HIGH = 2000;
  localparam int unsigned STOP_LIMIT = 1510;
  localparam int unsigned MAP_BASE   = 1500;
  localparam int unsigned MAP_SPAN   = 500;
  localparam int unsigned ROUND_STEP = 10;
  localparam int unsigned ROUND_HALF = 5;

  localparam int unsigned CMP_BITS    = (COUNT_BITS > 11) ? COUNT_BITS : 11;
  localparam int unsigned REM10_BITS  = 4;
  localparam int unsigned DIST_BITS   = 9;
  localparam int unsigned MAG_BITS    = SPEED_BITS;
  localparam int unsigned PROD_BITS   = DIST_BITS + MAG_BITS;
  localparam int unsigned REM500_BITS = 9;
  localparam int unsigned CNT10_BITS  = $clog2(COUNT_BITS + 1);
  localparam int unsigned SCNT_BITS   = $clog2(PROD_BITS + 1);

  localparam logic [SPEED_BITS-1:0] MAX_SPEED_RESET = SPEED_BITS'(1000);

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_MIN_SPEED = 2'd0,
    CFG_MAX_SPEED = 2'd1
  } cfg_idx_e;

  typedef logic [COUNT_BITS-1:0] count_t;
  typedef logic [SPEED_BITS-1:0] speed_t;

  typedef struct packed {
    logic                 start;
    logic [DIST_BITS-1:0] delta;
    logic [MAG_BITS-1:0]  mag;
  } scale_req_t;

  typedef struct packed {
    logic                done;
    logic [MAG_BITS-1:0] quot;
  } scale_rsp_t;

endpackage

>>> hw/rtl/pwm_pulse_throttle_decoder.sv
// Throughput: one item per cycle for rising edges while idle; a falling edge stalls the input
// through the bit-serial remainder, the range check, the serial multiply/divide (speed only)
// and, if a result is due, its load into the output register, plus any output stall.
// Reset: asynchronous, active low; disarms, clears rise and previous width, 0..1000 range.
// ----------------------------------------------------------------------------
// pwm_pulse_throttle_decoder
// Servo PWM throttle pulse decoder: capture events in, stop or speed ramp out.
// ----------------------------------------------------------------------------
module pwm_pulse_throttle_decoder (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [pwmd_pkg::CFG_IDX_BITS-1:0] cfg_index_i,
  input  logic [pwmd_pkg::SPEED_BITS-1:0]   cfg_data_i,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [pwmd_pkg::COUNT_BITS-1:0]   capture_count_i,
  input  logic                              pin_level_i,
  input  logic                              motor_idle_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic                              action_o,
  output logic signed [pwmd_pkg::SPEED_BITS-1:0] target_speed_o,
  output logic                              start_motor_o
);

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_MOD    = 5'b00010,
    ST_CHECK  = 5'b00100,
    ST_SCALE  = 5'b01000,
    ST_FINISH = 5'b10000
  } state_e;

  state_e                                state_q, state_d;
  logic                                  armed_q, armed_d;
  pwmd_pkg::count_t                      rise_q, rise_d;
  pwmd_pkg::count_t                      prev_q, prev_d;
  pwmd_pkg::count_t                      width_q, width_d;
  pwmd_pkg::count_t                      round_q, round_d;
  logic                                  idle_q, idle_d;
  logic                                  neg_q, neg_d;
  pwmd_pkg::speed_t                      min_q, max_q;
  logic                                  res_action_q, res_action_d;
  pwmd_pkg::speed_t                      res_speed_q, res_speed_d;
  logic                                  res_start_q, res_start_d;
  logic                                  out_valid_q, out_valid_d;
  logic                                  out_action_q;
  pwmd_pkg::speed_t                      out_speed_q;
  logic                                  out_start_q;
  logic                                  out_load;
  logic                                  in_xfer;
  logic                                  cfg_xfer;
  logic                                  mod_start;
  logic                                  mod_done;
  logic [pwmd_pkg::REM10_BITS-1:0]       mod_rem;
  pwmd_pkg::scale_req_t                  scale_req;
  pwmd_pkg::scale_rsp_t                  scale_rsp;
  logic [pwmd_pkg::CMP_BITS-1:0]         round_ext;
  logic [pwmd_pkg::SPEED_BITS:0]         span;
  pwmd_pkg::speed_t                      quot_signed;

  assign cfg_ready_o = 1'b1;
  assign cfg_xfer    = cfg_valid_i && cfg_ready_o;
  assign in_stall_o  = (state_q != ST_IDLE);
  assign in_xfer     = in_valid_i && !in_stall_o;

  pwmd_mod10 u_mod10 (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mod_start),
    .value_i (width_d),
    .done_o  (mod_done),
    .rem_o   (mod_rem)
  );

  pwmd_scale u_scale (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (scale_req),
    .rsp_o  (scale_rsp)
  );

  assign round_ext   = pwmd_pkg::CMP_BITS'(round_q);
  assign span        = {max_q[pwmd_pkg::SPEED_BITS-1], max_q}
                     - {min_q[pwmd_pkg::SPEED_BITS-1], min_q};
  assign quot_signed = neg_q ? pwmd_pkg::SPEED_BITS'(-scale_rsp.quot) : scale_rsp.quot;

  always_comb begin
    state_d         = state_q;
    armed_d         = armed_q;
    rise_d          = rise_q;
    prev_d          = prev_q;
    width_d         = width_q;
    round_d         = round_q;
    idle_d          = idle_q;
    neg_d           = neg_q;
    res_action_d    = res_action_q;
    res_speed_d     = res_speed_q;
    res_start_d     = res_start_q;
    mod_start       = 1'b0;
    scale_req       = '0;
    scale_req.delta = pwmd_pkg::DIST_BITS'(round_ext - pwmd_pkg::CMP_BITS'(pwmd_pkg::MAP_BASE));
    scale_req.mag   = span[pwmd_pkg::SPEED_BITS]
                    ? pwmd_pkg::MAG_BITS'(-span) : pwmd_pkg::MAG_BITS'(span);
    out_load        = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          idle_d = motor_idle_i;
          if (!armed_q) begin
            if (pin_level_i) begin
              armed_d = 1'b1;
              rise_d  = capture_count_i;
            end
          end else if (!pin_level_i) begin
            armed_d = 1'b0;
            width_d = capture_count_i - rise_q
                    + pwmd_pkg::COUNT_BITS'(pwmd_pkg::ROUND_HALF);
            state_d = ST_MOD;
          end
        end
      end
      ST_MOD: begin
        if (width_q == width_d && !mod_done && round_q == round_d) begin
          mod_start = 1'b0;
        end
        if (mod_done) begin
          round_d = width_q - pwmd_pkg::COUNT_BITS'(mod_rem);
          state_d = ST_CHECK;
        end
      end
      ST_CHECK: begin
        state_d = ST_IDLE;
        if (round_q != prev_q) begin
          prev_d = round_q;
          if (round_ext >= pwmd_pkg::CMP_BITS'(pwmd_pkg::WIDTH_LOW)
              && round_ext <= pwmd_pkg::CMP_BITS'(pwmd_pkg::WIDTH_HIGH)) begin
            if (round_ext <= pwmd_pkg::CMP_BITS'(pwmd_pkg::STOP_LIMIT)) begin
              if (!idle_q) begin
                res_action_d = 1'b0;
                res_speed_d  = '0;
                res_start_d  = 1'b0;
                state_d      = ST_FINISH;
              end
            end else begin
              neg_d           = span[pwmd_pkg::SPEED_BITS];
              scale_req.start = 1'b1;
              state_d         = ST_SCALE;
            end
          end
        end
      end
      ST_SCALE: begin
        if (scale_rsp.done) begin
          res_action_d = 1'b1;
          res_speed_d  = min_q + quot_signed;
          res_start_d  = idle_q;
          state_d      = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (!out_valid_q || !out_stall_i) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
    if (state_q == ST_IDLE && in_xfer && armed_q && !pin_level_i) begin
      mod_start = 1'b1;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    if (out_load) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      armed_q     <= 1'b0;
      rise_q      <= '0;
      prev_q      <= '0;
      min_q       <= '0;
      max_q       <= pwmd_pkg::MAX_SPEED_RESET;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      armed_q     <= armed_d;
      rise_q      <= rise_d;
      prev_q      <= prev_d;
      out_valid_q <= out_valid_d;
      if (cfg_xfer) begin
        unique case (cfg_index_i)
          pwmd_pkg::CFG_MIN_SPEED: min_q <= cfg_data_i;
          pwmd_pkg::CFG_MAX_SPEED: max_q <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    width_q      <= width_d;
    round_q      <= round_d;
    idle_q       <= idle_d;
    neg_q        <= neg_d;
    res_action_q <= res_action_d;
    res_speed_q  <= res_speed_d;
    res_start_q  <= res_start_d;
    if (out_load) begin
      out_action_q <= res_action_q;
      out_speed_q  <= res_speed_q;
      out_start_q  <= res_start_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign action_o       = out_action_q;
  assign target_speed_o = out_speed_q;
  assign start_motor_o  = out_start_q;

endmodule

>>> hw/rtl/pwmd_mod10.sv
// ----------------------------------------------------------------------------
// pwmd_mod10
// Bit-serial remainder by ten, one count bit per cycle, MSB first.
// ----------------------------------------------------------------------------
module pwmd_mod10 (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start_i,
  input  pwmd_pkg::count_t                   value_i,
  output logic                               done_o,
  output logic [pwmd_pkg::REM10_BITS-1:0]    rem_o
);

  pwmd_pkg::count_t                      value_q, value_d;
  logic [pwmd_pkg::REM10_BITS-1:0]       rem_q, rem_d;
  logic [pwmd_pkg::CNT10_BITS-1:0]       cnt_q, cnt_d;
  logic                                  done_q, done_d;
  logic [pwmd_pkg::REM10_BITS:0]         trial;

  always_comb begin
    value_d = value_q;
    rem_d   = rem_q;
    cnt_d   = cnt_q;
    done_d  = 1'b0;
    trial   = {rem_q, value_q[pwmd_pkg::COUNT_BITS-1]};
    if (start_i) begin
      value_d = value_i;
      rem_d   = '0;
      cnt_d   = pwmd_pkg::CNT10_BITS'(pwmd_pkg::COUNT_BITS);
    end else if (cnt_q != '0) begin
      if (trial >= (pwmd_pkg::REM10_BITS + 1)'(pwmd_pkg::ROUND_STEP)) begin
        rem_d = pwmd_pkg::REM10_BITS'(trial - (pwmd_pkg::REM10_BITS + 1)'(pwmd_pkg::ROUND_STEP));
      end else begin
        rem_d = trial[pwmd_pkg::REM10_BITS-1:0];
      end
      value_d = {value_q[pwmd_pkg::COUNT_BITS-2:0], 1'b0};
      cnt_d   = cnt_q - 1'b1;
      done_d  = (cnt_q == pwmd_pkg::CNT10_BITS'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
    rem_q   <= rem_d;
  end

  assign done_o = done_q;
  assign rem_o  = rem_q;

endmodule

>>> hw/rtl/pwmd_scale.sv
// ----------------------------------------------------------------------------
// pwmd_scale
// Serial shift-add multiply of distance by span, then restoring divide by 500.
// ----------------------------------------------------------------------------
module pwmd_scale (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  pwmd_pkg::scale_req_t  req_i,
  output pwmd_pkg::scale_rsp_t  rsp_o
);

  typedef enum logic [2:0] {
    SC_IDLE = 3'b001,
    SC_MUL  = 3'b010,
    SC_DIV  = 3'b100
  } scale_state_e;

  scale_state_e                         state_q, state_d;
  logic [pwmd_pkg::SCNT_BITS-1:0]       cnt_q, cnt_d;
  logic                                 done_q, done_d;
  logic [pwmd_pkg::PROD_BITS-1:0]       acc_q, acc_d;
  logic [pwmd_pkg::DIST_BITS-1:0]       dist_q, dist_d;
  logic [pwmd_pkg::MAG_BITS-1:0]        mag_q, mag_d;
  logic [pwmd_pkg::REM500_BITS-1:0]     rem_q, rem_d;
  logic [pwmd_pkg::REM500_BITS:0]       trial;
  logic                                 fits;

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    done_d  = 1'b0;
    acc_d   = acc_q;
    dist_d  = dist_q;
    mag_d   = mag_q;
    rem_d   = rem_q;
    trial   = {rem_q, acc_q[pwmd_pkg::PROD_BITS-1]};
    fits    = trial >= (pwmd_pkg::REM500_BITS + 1)'(pwmd_pkg::MAP_SPAN);
    unique case (state_q)
      SC_IDLE: begin
        if (req_i.start) begin
          acc_d   = '0;
          dist_d  = req_i.delta;
          mag_d   = req_i.mag;
          rem_d   = '0;
          cnt_d   = pwmd_pkg::SCNT_BITS'(pwmd_pkg::DIST_BITS);
          state_d = SC_MUL;
        end
      end
      SC_MUL: begin
        acc_d  = {acc_q[pwmd_pkg::PROD_BITS-2:0], 1'b0}
               + (dist_q[pwmd_pkg::DIST_BITS-1] ? pwmd_pkg::PROD_BITS'(mag_q) : '0);
        dist_d = {dist_q[pwmd_pkg::DIST_BITS-2:0], 1'b0};
        cnt_d  = cnt_q - 1'b1;
        if (cnt_q == pwmd_pkg::SCNT_BITS'(1)) begin
          cnt_d   = pwmd_pkg::SCNT_BITS'(pwmd_pkg::PROD_BITS);
          state_d = SC_DIV;
        end
      end
      SC_DIV: begin
        if (fits) begin
          rem_d = pwmd_pkg::REM500_BITS'(trial
                - (pwmd_pkg::REM500_BITS + 1)'(pwmd_pkg::MAP_SPAN));
        end else begin
          rem_d = trial[pwmd_pkg::REM500_BITS-1:0];
        end
        acc_d = {acc_q[pwmd_pkg::PROD_BITS-2:0], fits};
        cnt_d = cnt_q - 1'b1;
        if (cnt_q == pwmd_pkg::SCNT_BITS'(1)) begin
          done_d  = 1'b1;
          state_d = SC_IDLE;
        end
      end
      default: state_d = SC_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SC_IDLE;
      cnt_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q  <= acc_d;
    dist_q <= dist_d;
    mag_q  <= mag_d;
    rem_q  <= rem_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = acc_q[pwmd_pkg::MAG_BITS-1:0];

endmodule

>>> hw/rtl/pwmd_checker.sv
// ----------------------------------------------------------------------------
// pwmd_checker
// Port-level checks on the throttle decoder, bound to the top level.
// ----------------------------------------------------------------------------
module pwmd_checker (
  input logic                                  clk_i,
  input logic                                  rst_ni,
  input logic                                  in_valid_i,
  input logic                                  in_stall_o,
  input logic                                  pin_level_i,
  input logic                                  out_valid_o,
  input logic                                  out_stall_i,
  input logic                                  action_o,
  input logic signed [pwmd_pkg::SPEED_BITS-1:0] target_speed_o,
  input logic                                  start_motor_o
);

  logic in_xfer;

  assign in_xfer = in_valid_i && !in_stall_o;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(action_o)
      && $stable(target_speed_o) && $stable(start_motor_o))
    else $error("stalled result changed");

  a_stop_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !action_o |-> target_speed_o == '0 && !start_motor_o)
    else $error("stop result carries speed or start");

  a_no_fast_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> !$rose(out_valid_o))
    else $error("result appeared right after an input transfer");

  a_rise_no_block: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer && pin_level_i |=> !in_stall_o)
    else $error("high level blocked the input");

endmodule

bind pwm_pulse_throttle_decoder pwmd_checker u_pwmd_checker (.*);

>>> dv/pwm_pulse_throttle_decoder_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// pwm_pulse_throttle_decoder_test
// Drives capture events through the throttle decoder under random gaps and
// stalls. Checks every transfer against the table or an in-bench pulse decoder.
// ----------------------------------------------------------------------------
module pwm_pulse_throttle_decoder_test;

  localparam logic ACT_STOP = 1'b0;
  localparam logic ACT_RAMP = 1'b1;
  localparam int   SETTLE_CYCLES = pwmd_pkg::COUNT_BITS + 44;
  localparam int   CYCLE_LIMIT = 400000;
  localparam int   PHASE_ITEMS = 55;

  typedef struct packed {
    logic             action;
    pwmd_pkg::speed_t speed;
    logic             start;
  } throttle_cmd_t;

  typedef struct packed {
    pwmd_pkg::count_t cnt;
    logic             level;
    logic             idle;
    logic             fixed;
    logic             has_cmd;
    throttle_cmd_t    cmd;
  } capture_t;

  localparam throttle_cmd_t NO_CMD   = '0;
  localparam throttle_cmd_t STOP_CMD = '{ACT_STOP, 16'd0, 1'b0};

  localparam capture_t DIRECTED [26] = '{
    '{16'hFFFF, 1'b0, 1'b0, 1'b1, 1'b0, NO_CMD},
    '{16'd100,  1'b1, 1'b1, 1'b1, 1'b0, NO_CMD},
    '{16'd5000, 1'b1, 1'b0, 1'b1, 1'b0, NO_CMD},
    '{16'd2100, 1'b0, 1'b1, 1'b1, 1'b1, '{ACT_RAMP, 16'd1000, 1'b1}},
    '{16'd65520, 1'b1, 1'b0, 1'b1, 1'b0, NO_CMD},
    '{16'd1984, 1'b0, 1'b0, 1'b1, 1'b0, NO_CMD},
    '{16'd0,    1'b1, 1'b0, 1'b1, 1'b0, NO_CMD},
    '{16'd1500, 1'b0, 1'b0, 1'b1, 1'b1, STOP_CMD},
    '{16'd0,    1'b1, 1'b1, 1'b1, 1'b0, NO_CMD},
    '{16'd1510, 1'b0, 1'b1, 1'b1, 1'b0, NO_CMD},
    '{16'd10,   1'b1, 1'b0, 1'b1, 1'b0, NO_CMD},
    '{16'd1524, 1'b0, 1'b0, 1'b1, 1'b0, NO_CMD},
    '{16'd0,    1'b1, 1'b0, 1'b1, 1'b0, NO_CMD},
    '{16'd1515, 1'b0, 1'b0, 1'b1, 1'b1, '{ACT_RAMP, 16'd40, 1'b0}},
    '{16'd0,    1'b1, 1'b0, 1'b1, 1'b0, NO_CMD},
    '{16'd999,  1'b0, 1'b0, 1'b1, 1'b1, STOP_CMD},
    '{16'd0,    1'b1, 1'b0, 1'b1, 1'b0, NO_CMD},
    '{16'd994,  1'b0, 1'b0, 1'b1, 1'b0, NO_CMD},
    '{16'd0,    1'b1, 1'b0, 1'b1, 1'b0, NO_CMD},
    '{16'd2004, 1'b0, 1'b0, 1'b1, 1'b1, '{ACT_RAMP, 16'd1000, 1'b0}},
    '{16'd0,    1'b1, 1'b0, 1'b1, 1'b0, NO_CMD},
    '{16'd2005, 1'b0, 1'b0, 1'b1, 1'b0, NO_CMD},
    '{16'd1,    1'b1, 1'b0, 1'b1, 1'b0, NO_CMD},
    '{16'd0,    1'b0, 1'b0, 1'b1, 1'b0, NO_CMD},
    '{16'd200,  1'b1, 1'b1, 1'b0, 1'b0, NO_CMD},
    '{16'd1950, 1'b0, 1'b1, 1'b0, 1'b0, NO_CMD}
  };

  localparam pwmd_pkg::speed_t MIN_SETTINGS [4] = '{16'h8000, 16'h7FFF, 16'h0000, 16'h8000};
  localparam pwmd_pkg::speed_t MAX_SETTINGS [4] = '{16'h7FFF, 16'h8000, 16'h0000, 16'h8000};

  logic                              clk_i = 1'b0;
  logic                              rst_ni = 1'b0;
  logic                              cfg_valid_i = 1'b0;
  logic                              cfg_ready_o;
  logic [pwmd_pkg::CFG_IDX_BITS-1:0] cfg_index_i = '0;
  pwmd_pkg::speed_t                  cfg_data_i = '0;
  logic                              in_valid_i = 1'b0;
  logic                              in_stall_o;
  pwmd_pkg::count_t                  capture_count_i = '0;
  logic                              pin_level_i = 1'b0;
  logic                              motor_idle_i = 1'b0;
  logic                              out_valid_o;
  logic                              out_stall_i = 1'b0;
  logic                              action_o;
  logic signed [pwmd_pkg::SPEED_BITS-1:0] target_speed_o;
  logic                              start_motor_o;

  pwmd_pkg::speed_t min_spd = 16'd0;
  pwmd_pkg::speed_t max_spd = pwmd_pkg::MAX_SPEED_RESET;
  logic             armed = 1'b0;
  pwmd_pkg::count_t rise_cnt = '0;
  pwmd_pkg::count_t prev_width = '0;
  throttle_cmd_t    pending_cmds [$];
  int               mismatches = 0;
  int unsigned      cycles = 0;
  int unsigned      hold_left = 0;
  int unsigned      last_width = 1500;
  bit               no_gaps = 1'b0;

  pwm_pulse_throttle_decoder dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .capture_count_i (capture_count_i),
    .pin_level_i     (pin_level_i),
    .motor_idle_i    (motor_idle_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .action_o        (action_o),
    .target_speed_o  (target_speed_o),
    .start_motor_o   (start_motor_o)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  function automatic bit decode_capture(input pwmd_pkg::count_t cnt, input logic level,
                                        input logic idle, output throttle_cmd_t cmd);
    pwmd_pkg::count_t width;
    pwmd_pkg::count_t padded;
    pwmd_pkg::count_t rounded;
    longint lo;
    longint hi;
    longint spd;
    cmd = NO_CMD;
    if (!armed) begin
      if (level) begin
        armed = 1'b1;
        rise_cnt = cnt;
      end
      return 1'b0;
    end
    if (level) return 1'b0;
    armed = 1'b0;
    width = cnt - rise_cnt;
    padded = width + pwmd_pkg::count_t'(pwmd_pkg::ROUND_HALF);
    rounded = (padded / pwmd_pkg::count_t'(pwmd_pkg::ROUND_STEP))
            * pwmd_pkg::count_t'(pwmd_pkg::ROUND_STEP);
    if (rounded == prev_width) return 1'b0;
    prev_width = rounded;
    if (rounded < pwmd_pkg::WIDTH_LOW || rounded > pwmd_pkg::WIDTH_HIGH) return 1'b0;
    if (rounded <= pwmd_pkg::STOP_LIMIT) return !idle;
    lo = longint'($signed(min_spd));
    hi = longint'($signed(max_spd));
    spd = lo + ((longint'(rounded) - longint'(pwmd_pkg::MAP_BASE)) * (hi - lo))
        / longint'(pwmd_pkg::MAP_SPAN);
    cmd.action = ACT_RAMP;
    cmd.speed = pwmd_pkg::speed_t'(spd);
    cmd.start = idle;
    return 1'b1;
  endfunction

  task automatic flag_mismatch(input string what);
    mismatches++;
    if (mismatches <= 40) $display("[%0t] mismatch: %s", $time, what);
  endtask

  task automatic send_capture(input capture_t ev);
    int unsigned   gap;
    throttle_cmd_t cmd;
    bit            got;
    gap = no_gaps ? 0 : $urandom_range(0, 9);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    capture_count_i <= ev.cnt;
    pin_level_i <= ev.level;
    motor_idle_i <= ev.idle;
    do @(posedge clk_i); while (in_stall_o);
    got = decode_capture(ev.cnt, ev.level, ev.idle, cmd);
    if (ev.fixed) begin
      if (ev.has_cmd) pending_cmds.push_back(ev.cmd);
    end else if (got) begin
      pending_cmds.push_back(cmd);
    end
  endtask

  task automatic write_reg(input pwmd_pkg::cfg_idx_e idx, input pwmd_pkg::speed_t val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      pwmd_pkg::CFG_MIN_SPEED: min_spd = val;
      pwmd_pkg::CFG_MAX_SPEED: max_spd = val;
      default: ;
    endcase
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (pending_cmds.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  function automatic int unsigned pick_width();
    case ($urandom_range(0, 7))
      0: return last_width;
      1: return $urandom_range(1495, 1525);
      2: return $urandom_range(0, 65535);
      3: return $urandom_range(990, 1010);
      4: return $urandom_range(1990, 2010);
      default: return $urandom_range(950, 2050);
    endcase
  endfunction

  task automatic run_random(input int n);
    capture_t         ev;
    pwmd_pkg::count_t rise;
    int unsigned      w;
    for (int i = 0; i < n; i++) begin
      no_gaps = ((i / 12) % 4) == 3;
      ev = '0;
      ev.idle = 1'($urandom_range(0, 1));
      ev.cnt = pwmd_pkg::count_t'($urandom);
      case ($urandom_range(0, 9))
        7: begin
          ev.level = 1'b0;
          send_capture(ev);
        end
        8: begin
          ev.level = 1'b1;
          send_capture(ev);
        end
        9: begin
          ev.level = 1'($urandom_range(0, 1));
          send_capture(ev);
        end
        default: begin
          rise = pwmd_pkg::count_t'($urandom);
          w = pick_width();
          ev.cnt = rise;
          ev.level = 1'b1;
          send_capture(ev);
          if ($urandom_range(0, 7) == 0) begin
            ev.cnt = pwmd_pkg::count_t'($urandom);
            send_capture(ev);
          end
          ev.cnt = rise + pwmd_pkg::count_t'(w);
          ev.level = 1'b0;
          ev.idle = 1'($urandom_range(0, 1));
          send_capture(ev);
          last_width = w;
        end
      endcase
    end
    no_gaps = 1'b0;
  endtask

  always @(posedge clk_i) begin
    throttle_cmd_t want;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (pending_cmds.size() == 0) begin
          flag_mismatch("transfer with nothing pending");
        end else begin
          want = pending_cmds.pop_front();
          if (action_o !== want.action)
            flag_mismatch($sformatf("action %b, want %b", action_o, want.action));
          if (target_speed_o !== want.speed)
            flag_mismatch($sformatf("target_speed %0d, want %0d", target_speed_o,
                                    $signed(want.speed)));
          if (start_motor_o !== want.start)
            flag_mismatch($sformatf("start_motor %b, want %b", start_motor_o, want.start));
        end
        hold_left = no_gaps ? 0 : $urandom_range(0, 9);
      end else if (out_valid_o && hold_left != 0) begin
        hold_left--;
      end
      out_stall_i <= (hold_left != 0);
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles == CYCLE_LIMIT) begin
      $display("[pwm_pulse_throttle_decoder] ERROR");
      $finish;
    end
  end

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (DIRECTED[k]) send_capture(DIRECTED[k]);
    run_random(PHASE_ITEMS);
    for (int p = 0; p < 4; p++) begin
      drain_results();
      write_reg(pwmd_pkg::CFG_MIN_SPEED,
                (p == 2) ? pwmd_pkg::speed_t'($urandom) : MIN_SETTINGS[p]);
      write_reg(pwmd_pkg::CFG_MAX_SPEED,
                (p == 2) ? pwmd_pkg::speed_t'($urandom) : MAX_SETTINGS[p]);
      run_random(PHASE_ITEMS);
    end
    drain_results();
    if (mismatches == 0) begin
      $display("[pwm_pulse_throttle_decoder] OK");
    end else begin
      $display("[pwm_pulse_throttle_decoder] ERROR");
    end
    $finish;
  end

endmodule
